/* rtl/cdvs_pkg.sv */
// Shared types, widths and constants of the critically damped vector smoother.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package cdvs_pkg;

	// Fraction bits of positions and smooth_time
	localparam int FRAC_BITS = 16;

	// Configuration register
	localparam int ST_W = 21;
	localparam logic [ST_W-1:0] ST_RESET = 21'd9830;
	// 0.0001 s rounded up to the next LSB
	localparam int SMOOTH_MIN_I = ((1 << FRAC_BITS) + 9999) / 10000;
	localparam logic [ST_W-1:0] SMOOTH_MIN = ST_W'(SMOOTH_MIN_I);

	// Scalar widths
	localparam int DT_W    = 16;
	localparam int OMEGA_W = 32;
	localparam int E_W     = 33;
	localparam int X_W     = 27;
	localparam int X2_W    = 37;
	localparam int X3_W    = 47;
	localparam int KX2_W   = 36;
	localparam int DEN_W   = 45;
	localparam logic [X_W-1:0] X_CAP = X_W'(1024 << 16);
	localparam logic [15:0] K_048  = 16'd31457;
	localparam logic [15:0] K_0235 = 16'd15401;

	// Sequential multiplier: A x B, B taken one byte per cycle
	localparam int MUL_A_W   = 64;
	localparam int MUL_B_W   = 34;
	localparam int MUL_P_W   = 98;
	localparam int MUL_DIG   = 8;
	localparam int MUL_STEPS = (MUL_B_W + MUL_DIG - 1) / MUL_DIG;

	// Restoring divider
	localparam int DIV_N_W = 49;
	localparam int DIV_D_W = DEN_W;
	localparam logic [DIV_N_W-1:0] OMEGA_NUM = DIV_N_W'(1) << (FRAC_BITS + 17);
	localparam logic [DIV_N_W-1:0] E_NUM     = DIV_N_W'(1) << 48;

	// Magnitude limit of intermediate products
	localparam logic [62:0] SAT62 = 63'h4000_0000_0000_0000;

	localparam int DOT_W = 67;

	// Per-item factors shared by all lanes
	typedef struct packed {
		logic [OMEGA_W-1:0] omega;
		logic [DT_W-1:0]    dt;
		logic [E_W-1:0]     e;
	} lane_cmd_t;

	// What each lane hands to the merge stage
	typedef struct packed {
		logic signed [31:0]      nout;
		logic signed [31:0]      nvel;
		logic signed [DOT_W-1:0] dot;
	} lane_res_t;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (v > 65'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -65'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/critically_damped_vector_smoother.sv */
// Critically damped spring smoother for a three-axis point, signed Q16.16.
// Uses cdvs_pkg, cdvs_mul, cdvs_div and three cdvs_lane instances.
// An item with restart set or with zero delta_time goes straight to the output state. Any other item runs a
// sequence on one shared divider and multiplier followed by the three axis lanes in parallel:
// five scalar multiplies, a divide for the decay factor, six lane multiplies, a merge state
// and an output state. The first such item after reset or after a smooth_time write adds
// another divide for omega. Multiplies take one byte of the second operand per cycle and
// divides one quotient bit per cycle. Input stall stays high from the accepted transaction
// until the result sits in the output register.
`default_nettype none

module critically_damped_vector_smoother (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [cdvs_pkg::ST_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [31:0]            target_x,
	input  logic signed [31:0]            target_y,
	input  logic signed [31:0]            target_z,
	input  logic [cdvs_pkg::DT_W-1:0]     delta_time,
	input  logic                          restart,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [31:0]            smooth_x,
	output logic signed [31:0]            smooth_y,
	output logic signed [31:0]            smooth_z,
	output logic                          snapped
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_OMEGA = 11'b000_0000_0010,
		ST_X     = 11'b000_0000_0100,
		ST_X2    = 11'b000_0000_1000,
		ST_X3    = 11'b000_0001_0000,
		ST_K2    = 11'b000_0010_0000,
		ST_K3    = 11'b000_0100_0000,
		ST_E     = 11'b000_1000_0000,
		ST_LANE  = 11'b001_0000_0000,
		ST_MERGE = 11'b010_0000_0000,
		ST_OUT   = 11'b100_0000_0000
	} state_t;

	state_t                          state_q;
	logic                            launch_q;
	logic                            out_valid_q;
	logic                            omega_ok_q;
	logic [cdvs_pkg::ST_W-1:0]       smooth_time_q;
	logic signed [31:0]              pos_q [3];
	logic signed [31:0]              vel_q [3];

	logic signed [31:0]              tgt_q [3];
	logic [cdvs_pkg::DT_W-1:0]       dt_q;
	logic [cdvs_pkg::OMEGA_W-1:0]    omega_q;
	logic [cdvs_pkg::X_W-1:0]        x_q;
	logic [cdvs_pkg::X2_W-1:0]       x2_q;
	logic [cdvs_pkg::X3_W-1:0]       x3_q;
	logic [cdvs_pkg::KX2_W-1:0]      kx2_q;
	logic [cdvs_pkg::DEN_W-1:0]      den_q;
	logic [cdvs_pkg::E_W-1:0]        e_q;
	logic                            snap_q;

	logic                            accept;
	logic                            out_free;
	logic                            mul_start;
	logic [cdvs_pkg::MUL_A_W-1:0]    mul_a;
	logic [cdvs_pkg::MUL_B_W-1:0]    mul_b;
	logic [cdvs_pkg::MUL_P_W-1:0]    mul_prod;
	logic                            mul_done;
	logic [cdvs_pkg::MUL_P_W-1:0]    prod_sh;
	logic                            div_start;
	logic [cdvs_pkg::DIV_N_W-1:0]    div_num;
	logic [cdvs_pkg::DIV_D_W-1:0]    div_dvs;
	logic [cdvs_pkg::DIV_N_W-1:0]    div_quot;
	logic                            div_done;
	logic [cdvs_pkg::ST_W-1:0]       st_floor;
	logic [cdvs_pkg::X_W-1:0]        x_c;
	cdvs_pkg::lane_cmd_t             cmd;
	cdvs_pkg::lane_res_t             lane_res [3];
	logic [2:0]                      lane_done;
	logic                            lane_start;
	logic signed [cdvs_pkg::DOT_W:0] dot_sum;
	logic                            snap_c;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign st_floor = (smooth_time_q < cdvs_pkg::SMOOTH_MIN) ? cdvs_pkg::SMOOTH_MIN
	                                                         : smooth_time_q;

	// shared scalar multiplier operands
	always_comb begin
		case (state_q)
			ST_X: begin
				mul_a = cdvs_pkg::MUL_A_W'(omega_q);
				mul_b = cdvs_pkg::MUL_B_W'(dt_q);
			end
			ST_X2: begin
				mul_a = cdvs_pkg::MUL_A_W'(x_q);
				mul_b = cdvs_pkg::MUL_B_W'(x_q);
			end
			ST_X3: begin
				mul_a = cdvs_pkg::MUL_A_W'(x2_q);
				mul_b = cdvs_pkg::MUL_B_W'(x_q);
			end
			ST_K2: begin
				mul_a = cdvs_pkg::MUL_A_W'(x2_q);
				mul_b = cdvs_pkg::MUL_B_W'(cdvs_pkg::K_048);
			end
			ST_K3: begin
				mul_a = cdvs_pkg::MUL_A_W'(x3_q);
				mul_b = cdvs_pkg::MUL_B_W'(cdvs_pkg::K_0235);
			end
			default: begin
				mul_a = cdvs_pkg::MUL_A_W'(x_q);
				mul_b = cdvs_pkg::MUL_B_W'(x_q);
			end
		endcase
	end

	assign mul_start = launch_q && ((state_q == ST_X) || (state_q == ST_X2) ||
	                   (state_q == ST_X3) || (state_q == ST_K2) || (state_q == ST_K3));
	assign prod_sh   = mul_prod >> 16;
	assign x_c       = (prod_sh > cdvs_pkg::MUL_P_W'(cdvs_pkg::X_CAP)) ? cdvs_pkg::X_CAP
	                                                                   : prod_sh[cdvs_pkg::X_W-1:0];

	cdvs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	// omega = 2 / smooth_time, decay = 1 / den
	assign div_start = launch_q && ((state_q == ST_OMEGA) || (state_q == ST_E));
	assign div_num   = (state_q == ST_OMEGA) ? cdvs_pkg::OMEGA_NUM : cdvs_pkg::E_NUM;
	assign div_dvs   = (state_q == ST_OMEGA) ? cdvs_pkg::DIV_D_W'(st_floor) : den_q;

	cdvs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_dvs),
		.quot     (div_quot),
		.done     (div_done)
	);

	// axis lanes
	assign cmd.omega  = omega_q;
	assign cmd.dt     = dt_q;
	assign cmd.e      = e_q;
	assign lane_start = launch_q && (state_q == ST_LANE);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		cdvs_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (lane_start),
			.tgt    (tgt_q[i]),
			.pos    (pos_q[i]),
			.vel    (vel_q[i]),
			.cmd    (cmd),
			.res    (lane_res[i]),
			.done   (lane_done[i])
		);
	end

	// merge: overshoot when the summed dot product is positive
	assign dot_sum = {lane_res[0].dot[cdvs_pkg::DOT_W-1], lane_res[0].dot}
	               + {lane_res[1].dot[cdvs_pkg::DOT_W-1], lane_res[1].dot}
	               + {lane_res[2].dot[cdvs_pkg::DOT_W-1], lane_res[2].dot};
	assign snap_c  = (dot_sum > 0);

	// output valid: set when a result is loaded, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			launch_q      <= 1'b0;
			omega_ok_q    <= 1'b0;
			smooth_time_q <= cdvs_pkg::ST_RESET;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				vel_q[i] <= '0;
			end
		end else begin
			launch_q <= 1'b0;
			if (cfg_write) begin
				smooth_time_q <= cfg_data;
				omega_ok_q    <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (restart) begin
							pos_q[0] <= target_x;
							pos_q[1] <= target_y;
							pos_q[2] <= target_z;
							for (int i = 0; i < 3; i++) begin
								vel_q[i] <= '0;
							end
							state_q <= ST_OUT;
						end else if (delta_time == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q  <= omega_ok_q ? ST_X : ST_OMEGA;
							launch_q <= 1'b1;
						end
					end
				end
				ST_OMEGA: begin
					if (div_done) begin
						omega_ok_q <= 1'b1;
						state_q    <= ST_X;
						launch_q   <= 1'b1;
					end
				end
				ST_X: begin
					if (mul_done) begin
						state_q  <= ST_X2;
						launch_q <= 1'b1;
					end
				end
				ST_X2: begin
					if (mul_done) begin
						state_q  <= ST_X3;
						launch_q <= 1'b1;
					end
				end
				ST_X3: begin
					if (mul_done) begin
						state_q  <= ST_K2;
						launch_q <= 1'b1;
					end
				end
				ST_K2: begin
					if (mul_done) begin
						state_q  <= ST_K3;
						launch_q <= 1'b1;
					end
				end
				ST_K3: begin
					if (mul_done) begin
						state_q  <= ST_E;
						launch_q <= 1'b1;
					end
				end
				ST_E: begin
					if (div_done) begin
						state_q  <= ST_LANE;
						launch_q <= 1'b1;
					end
				end
				ST_LANE: begin
					if (&lane_done) begin
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					for (int i = 0; i < 3; i++) begin
						pos_q[i] <= snap_c ? tgt_q[i] : lane_res[i].nout;
						vel_q[i] <= snap_c ? 32'sd0 : lane_res[i].nvel;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload and intermediate values
	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q[0] <= target_x;
			tgt_q[1] <= target_y;
			tgt_q[2] <= target_z;
			dt_q     <= delta_time;
			snap_q   <= 1'b0;
		end
		if ((state_q == ST_OMEGA) && div_done) begin
			omega_q <= div_quot[cdvs_pkg::OMEGA_W-1:0];
		end
		if (mul_done) begin
			case (state_q)
				ST_X:    x_q   <= x_c;
				ST_X2:   x2_q  <= prod_sh[cdvs_pkg::X2_W-1:0];
				ST_X3:   x3_q  <= prod_sh[cdvs_pkg::X3_W-1:0];
				ST_K2:   kx2_q <= prod_sh[cdvs_pkg::KX2_W-1:0];
				ST_K3:   den_q <= cdvs_pkg::DEN_W'(65536) + cdvs_pkg::DEN_W'(x_q)
				                + cdvs_pkg::DEN_W'(kx2_q) + prod_sh[cdvs_pkg::DEN_W-1:0];
				default: x_q   <= x_q;
			endcase
		end
		if ((state_q == ST_E) && div_done) begin
			e_q <= div_quot[cdvs_pkg::E_W-1:0];
		end
		if (state_q == ST_MERGE) begin
			snap_q <= snap_c;
		end
		if ((state_q == ST_OUT) && out_free) begin
			smooth_x <= pos_q[0];
			smooth_y <= pos_q[1];
			smooth_z <= pos_q[2];
			snapped  <= snap_q;
		end
	end

	assign out_valid = out_valid_q;

	// lanes run in lockstep
	a_lane_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(|lane_done) |-> (&lane_done))
		else $error("axis lanes finished out of step");

	// an accepted transaction always starts work
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("accepted transaction left the sequencer idle");

	// a snap lands axis 0 exactly on the target with zero velocity
	a_snap_target: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_MERGE) && snap_c) |=>
		((pos_q[0] == $past(tgt_q[0])) && (vel_q[0] == 32'sd0)))
		else $error("snap did not load the target");

	// a new result only comes from the output state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_OUT))
		else $error("result raised outside the output state");

endmodule

`default_nettype wire

/* rtl/cdvs_mul.sv */
// Sequential unsigned multiplier, one byte of B per cycle.
// Depends on cdvs_pkg for widths.
`default_nettype none

module cdvs_mul (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [cdvs_pkg::MUL_A_W-1:0]    a,
	input  logic [cdvs_pkg::MUL_B_W-1:0]    b,
	output logic [cdvs_pkg::MUL_P_W-1:0]    prod,
	output logic                            done
);

	localparam int CNT_W = $clog2(cdvs_pkg::MUL_STEPS);

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [cdvs_pkg::MUL_P_W-1:0] a_q;
	logic [cdvs_pkg::MUL_B_W-1:0] b_q;
	logic [cdvs_pkg::MUL_P_W-1:0] acc_q;
	logic [cdvs_pkg::MUL_P_W-1:0] pp;

	// partial product of one byte
	assign pp = a_q * cdvs_pkg::MUL_P_W'(b_q[cdvs_pkg::MUL_DIG-1:0]);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(cdvs_pkg::MUL_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= cdvs_pkg::MUL_P_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + pp;
			a_q   <= a_q << cdvs_pkg::MUL_DIG;
			b_q   <= b_q >> cdvs_pkg::MUL_DIG;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

`default_nettype wire

/* rtl/cdvs_div.sv */
// Restoring divider, one quotient bit per cycle.
// Depends on cdvs_pkg for widths.
`default_nettype none

module cdvs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cdvs_pkg::DIV_N_W-1:0]  dividend,
	input  logic [cdvs_pkg::DIV_D_W-1:0]  divisor,
	output logic [cdvs_pkg::DIV_N_W-1:0]  quot,
	output logic                          done
);

	localparam int CNT_W = $clog2(cdvs_pkg::DIV_N_W);
	localparam int R_W   = cdvs_pkg::DIV_D_W + 1;

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [cdvs_pkg::DIV_N_W-1:0] num_q;
	logic [cdvs_pkg::DIV_D_W-1:0] dvs_q;
	logic [R_W-1:0]               rem_q;
	logic [R_W-1:0]               rem_sh;
	logic                         ge;

	// shift in the next dividend bit and trial-subtract
	assign rem_sh = {rem_q[R_W-2:0], num_q[cdvs_pkg::DIV_N_W-1]};
	assign ge     = rem_sh >= R_W'(dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(cdvs_pkg::DIV_N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[cdvs_pkg::DIV_N_W-2:0], ge};
			rem_q <= ge ? (rem_sh - R_W'(dvs_q)) : rem_sh;
		end
	end

	assign quot = num_q;
	assign done = done_q;

endmodule

`default_nettype wire

/* rtl/cdvs_lane.sv */
// One axis of the smoother: spring update, overshoot dot term, own multiplier.
// Depends on cdvs_pkg and cdvs_mul.
`default_nettype none

module cdvs_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [31:0]         tgt,
	input  logic signed [31:0]         pos,
	input  logic signed [31:0]         vel,
	input  cdvs_pkg::lane_cmd_t        cmd,
	output cdvs_pkg::lane_res_t        res,
	output logic                       done
);

	localparam logic [2:0] STEP_P1   = 3'd0;  // chg * omega
	localparam logic [2:0] STEP_TMP  = 3'd1;  // (vel + p1) * dt
	localparam logic [2:0] STEP_P3   = 3'd2;  // tmp * omega
	localparam logic [2:0] STEP_VEL  = 3'd3;  // (vel - p3) * e
	localparam logic [2:0] STEP_OUT  = 3'd4;  // (chg + tmp) * e
	localparam logic [2:0] STEP_DOT  = 3'd5;  // (tgt - pos) * (out - tgt)

	logic                         busy_q;
	logic                         launch_q;
	logic                         done_q;
	logic [2:0]                   step_q;
	logic signed [63:0]           p1_q;
	logic signed [63:0]           tmp_q;
	logic signed [63:0]           p3_q;
	logic signed [31:0]           nvel_q;
	logic signed [31:0]           nout_q;
	logic signed [cdvs_pkg::DOT_W-1:0] dot_q;

	logic signed [32:0]           chg;
	logic signed [64:0]           chg_x;
	logic signed [64:0]           vel_x;
	logic signed [64:0]           tgt_x;
	logic signed [64:0]           opnd;
	logic signed [64:0]           opnd_abs;
	logic signed [32:0]           nd;
	logic [32:0]                  nd_abs;
	logic [cdvs_pkg::MUL_B_W-1:0] b_sel;
	logic                         neg;
	logic [cdvs_pkg::MUL_P_W-1:0] prod;
	logic                         mul_done;
	logic [cdvs_pkg::MUL_P_W-1:0] shifted;
	logic [62:0]                  mag;
	logic signed [63:0]           val;
	logic signed [64:0]           out_sum;

	assign chg   = {pos[31], pos} - {tgt[31], tgt};
	assign chg_x = {{32{chg[32]}}, chg};
	assign vel_x = {{33{vel[31]}}, vel};
	assign tgt_x = {{33{tgt[31]}}, tgt};
	assign nd    = {nout_q[31], nout_q} - {tgt[31], tgt};
	assign nd_abs = nd[32] ? 33'(-nd) : 33'(nd);

	// operand selection per step
	always_comb begin
		opnd  = chg_x;
		b_sel = cdvs_pkg::MUL_B_W'(cmd.omega);
		neg   = 1'b0;
		case (step_q)
			STEP_P1: begin
				opnd  = chg_x;
				b_sel = cdvs_pkg::MUL_B_W'(cmd.omega);
			end
			STEP_TMP: begin
				opnd  = vel_x + {p1_q[63], p1_q};
				b_sel = cdvs_pkg::MUL_B_W'(cmd.dt);
			end
			STEP_P3: begin
				opnd  = {tmp_q[63], tmp_q};
				b_sel = cdvs_pkg::MUL_B_W'(cmd.omega);
			end
			STEP_VEL: begin
				opnd  = vel_x - {p3_q[63], p3_q};
				b_sel = cdvs_pkg::MUL_B_W'(cmd.e);
			end
			STEP_OUT: begin
				opnd  = chg_x + {tmp_q[63], tmp_q};
				b_sel = cdvs_pkg::MUL_B_W'(cmd.e);
			end
			STEP_DOT: begin
				opnd  = 65'sd0 - chg_x;
				b_sel = cdvs_pkg::MUL_B_W'(nd_abs);
			end
			default: begin
				opnd  = chg_x;
				b_sel = cdvs_pkg::MUL_B_W'(cmd.omega);
			end
		endcase
		neg      = opnd[64] ^ ((step_q == STEP_DOT) & nd[32]);
		opnd_abs = opnd[64] ? -opnd : opnd;
	end

	cdvs_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (launch_q),
		.a      (opnd_abs[63:0]),
		.b      (b_sel),
		.prod   (prod),
		.done   (mul_done)
	);

	// truncate toward zero, saturate magnitude, restore sign
	assign shifted = ((step_q == STEP_VEL) || (step_q == STEP_OUT)) ? (prod >> 32) : (prod >> 16);
	assign mag     = (shifted > cdvs_pkg::MUL_P_W'(cdvs_pkg::SAT62)) ? cdvs_pkg::SAT62
	                                                                 : shifted[62:0];
	assign val     = neg ? -{1'b0, mag} : {1'b0, mag};
	assign out_sum = tgt_x + {val[63], val};

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			step_q   <= STEP_P1;
		end else begin
			launch_q <= 1'b0;
			done_q   <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				step_q   <= STEP_P1;
				launch_q <= 1'b1;
			end else if (busy_q && mul_done) begin
				if (step_q == STEP_DOT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q   <= step_q + 3'd1;
					launch_q <= 1'b1;
				end
			end
		end
	end

	// step results
	always_ff @(posedge clk) begin
		if (busy_q && mul_done) begin
			case (step_q)
				STEP_P1:  p1_q   <= val;
				STEP_TMP: tmp_q  <= val;
				STEP_P3:  p3_q   <= val;
				STEP_VEL: nvel_q <= cdvs_pkg::sat32({val[63], val});
				STEP_OUT: nout_q <= cdvs_pkg::sat32(out_sum);
				STEP_DOT: dot_q  <= neg ? -{1'b0, prod[65:0]} : {1'b0, prod[65:0]};
				default:  p1_q   <= p1_q;
			endcase
		end
	end

	assign res.nout = nout_q;
	assign res.nvel = nvel_q;
	assign res.dot  = dot_q;
	assign done     = done_q;

endmodule

`default_nettype wire
